// File: rtl/core/bmbx_pkg.sv
// ----------------------------------------------------------------------------
// bmbx_pkg
// Types and constants shared by the mailbox with wait queues.
// ----------------------------------------------------------------------------
package bmbx_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int ID_BITS     = 16;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] OP_STORE       = 3'd0;
   localparam logic [2:0] OP_STORE_NB    = 3'd1;
   localparam logic [2:0] OP_RETRIEVE    = 3'd2;
   localparam logic [2:0] OP_RETRIEVE_NB = 3'd3;
   localparam logic [2:0] OP_EXIT        = 3'd4;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_DATA    = 2'd1;
   localparam logic [1:0] ST_SLOT_FULL  = 2'd2;
   localparam logic [1:0] ST_QUEUE_FULL = 2'd3;

   typedef logic [PTR_BITS-1:0] ptr_type;

   typedef struct packed {
      logic [2:0]         op;
      logic [ID_BITS-1:0] requester_id;
      logic signed [31:0] data;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] dest_id;
      logic [1:0]         status;
      logic signed [31:0] reply_data;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic [31:0]        data;
   } sentry_type;

   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_next = (p == ptr_type'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_type'(1);
   endfunction

   function automatic ptr_type ptr_prev(input ptr_type p);
      ptr_prev = (p == '0) ? ptr_type'(QUEUE_DEPTH - 1) : p - ptr_type'(1);
   endfunction

endpackage

// File: rtl/core/blocking_mailbox_with_wait_queues.sv
// ----------------------------------------------------------------------------
// blocking_mailbox_with_wait_queues
// One-word mailbox slot with ring wait queues for blocked storers/retrievers.
// ----------------------------------------------------------------------------
// Replies: a result is registered out of S_EXEC, after S_RD has read the queue
// heads through the registered memory ports; a second reply follows from
// S_RSP2 on the next cycle.
// Busy: the block takes a new item only in S_IDLE; a store/retrieve passes
// S_RD and S_EXEC, and S_RSP2 when it makes two replies; an exit walks and
// shifts the rings through one read port per ring.
// Reset: synchronous; slot empty, queues empty, ring contents left undefined.
module blocking_mailbox_with_wait_queues (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bmbx_pkg::req_type req_item,
   output logic              busy,
   output logic              rsp_valid,
   output bmbx_pkg::rsp_type rsp_item
);
   import bmbx_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_EXEC  = 4'd2;
   localparam logic [3:0] S_RSP2  = 4'd3;
   localparam logic [3:0] S_SFIND = 4'd4;
   localparam logic [3:0] S_SSHFT = 4'd5;
   localparam logic [3:0] S_FFIND = 4'd6;
   localparam logic [3:0] S_FSHFT = 4'd7;
   localparam logic [3:0] S_HOLD  = 4'd8;
   localparam logic [3:0] S_HRD   = 4'd9;
   localparam logic [3:0] S_SWAIT = 4'd10;
   localparam logic [3:0] S_FWAIT = 4'd11;

   sentry_type         sring [QUEUE_DEPTH];
   logic [ID_BITS-1:0] fring [QUEUE_DEPTH];

   logic [3:0]   state_ff, state_in;
   req_type      req_ff, req_in;
   logic [31:0]  slot_value_ff, slot_value_in;
   logic         slot_full_ff, slot_full_in;
   logic [ID_BITS-1:0] holder_id_ff, holder_id_in;
   logic         holder_valid_ff, holder_valid_in;
   ptr_type      sh_ff, sh_in, st_ff, st_in, fh_ff, fh_in, ft_ff, ft_in;
   ptr_type      idx_ff, idx_in;
   logic         rv_ff, rv_in;
   rsp_type      rsp_ff, rsp_in;
   rsp_type      pend_ff, pend_in;

   // memory ports
   ptr_type      s_raddr, f_raddr, s_waddr, f_waddr;
   logic         s_we, f_we;
   sentry_type   s_wdata, s_rdata_ff;
   logic [ID_BITS-1:0] f_wdata, f_rdata_ff;

   always_ff @(posedge clock) begin
      if (s_we) sring[s_waddr] <= s_wdata;
      if (f_we) fring[f_waddr] <= f_wdata;
      s_rdata_ff <= sring[s_raddr];
      f_rdata_ff <= fring[f_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         slot_full_ff    <= 1'b0;
         holder_valid_ff <= 1'b0;
         slot_value_ff   <= '0;
         holder_id_ff    <= '0;
         sh_ff <= '0; st_ff <= '0; fh_ff <= '0; ft_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         slot_full_ff    <= slot_full_in;
         holder_valid_ff <= holder_valid_in;
         slot_value_ff   <= slot_value_in;
         holder_id_ff    <= holder_id_in;
         sh_ff <= sh_in; st_ff <= st_in; fh_ff <= fh_in; ft_ff <= ft_in;
         rv_ff <= rv_in;
      end
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_item  = rsp_ff;

   function automatic rsp_type mk(input logic [ID_BITS-1:0] d, input logic [1:0] s,
                                  input logic [31:0] v, input logic l);
      mk.dest_id = d; mk.status = s; mk.reply_data = v; mk.last = l;
   endfunction

   always_comb begin
      logic is_store, is_ret, s_empty, f_empty;
      is_store = (req_ff.op == OP_STORE) || (req_ff.op == OP_STORE_NB);
      is_ret   = (req_ff.op == OP_RETRIEVE) || (req_ff.op == OP_RETRIEVE_NB);
      s_empty  = (sh_ff == st_ff);
      f_empty  = (fh_ff == ft_ff);

      state_in = state_ff; req_in = req_ff;
      slot_value_in = slot_value_ff; slot_full_in = slot_full_ff;
      holder_id_in = holder_id_ff; holder_valid_in = holder_valid_ff;
      sh_in = sh_ff; st_in = st_ff; fh_in = fh_ff; ft_in = ft_ff;
      idx_in = idx_ff; rv_in = 1'b0; rsp_in = rsp_ff; pend_in = pend_ff;
      s_raddr = sh_ff; f_raddr = fh_ff;
      s_we = 1'b0; f_we = 1'b0; s_waddr = st_ff; f_waddr = ft_ff;
      s_wdata.id = req_ff.requester_id; s_wdata.data = req_ff.data;
      f_wdata = req_ff.requester_id;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_RD;
            end
         end
         S_RD: begin
            // heads addressed by default; data valid next cycle
            if (req_ff.op == OP_EXIT) begin
               idx_in = sh_ff;
               s_raddr = sh_ff;
               state_in = S_SFIND;
            end else
               state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (is_store) begin
               if (!slot_full_ff) begin
                  if (!f_empty) begin
                     fh_in   = ptr_next(fh_ff);
                     slot_value_in = req_ff.data;
                     holder_id_in  = req_ff.requester_id;
                     rv_in  = 1'b1;
                     rsp_in = mk(f_rdata_ff, ST_OK, req_ff.data, 1'b0);
                     pend_in = mk(req_ff.requester_id, ST_OK, req_ff.data, 1'b1);
                     state_in = S_RSP2;
                  end else begin
                     slot_value_in = req_ff.data; slot_full_in = 1'b1;
                     holder_id_in = req_ff.requester_id; holder_valid_in = 1'b1;
                     rv_in  = 1'b1;
                     rsp_in = mk(req_ff.requester_id, ST_OK, req_ff.data, 1'b1);
                  end
               end else if (req_ff.op == OP_STORE_NB) begin
                  rv_in  = 1'b1;
                  rsp_in = mk(req_ff.requester_id, ST_SLOT_FULL, req_ff.data, 1'b1);
               end else if (ptr_next(st_ff) == sh_ff) begin
                  rv_in  = 1'b1;
                  rsp_in = mk(req_ff.requester_id, ST_QUEUE_FULL, req_ff.data, 1'b1);
               end else begin
                  s_we  = 1'b1;
                  st_in = ptr_next(st_ff);
               end
            end else if (is_ret) begin
               if (slot_full_ff) begin
                  if (!s_empty) begin
                     sh_in = ptr_next(sh_ff);
                     slot_value_in = s_rdata_ff.data;
                     holder_id_in  = s_rdata_ff.id;
                     holder_valid_in = 1'b1;
                     rv_in  = 1'b1;
                     rsp_in = mk(s_rdata_ff.id, ST_OK, s_rdata_ff.data, 1'b0);
                     pend_in = mk(req_ff.requester_id, ST_OK, slot_value_ff, 1'b1);
                     state_in = S_RSP2;
                  end else begin
                     slot_full_in = 1'b0; holder_valid_in = 1'b0;
                     rv_in  = 1'b1;
                     rsp_in = mk(req_ff.requester_id, ST_OK, slot_value_ff, 1'b1);
                  end
               end else if (req_ff.op == OP_RETRIEVE_NB) begin
                  rv_in  = 1'b1;
                  rsp_in = mk(req_ff.requester_id, ST_NO_DATA, req_ff.data, 1'b1);
               end else if (ptr_next(ft_ff) == fh_ff) begin
                  rv_in  = 1'b1;
                  rsp_in = mk(req_ff.requester_id, ST_QUEUE_FULL, req_ff.data, 1'b1);
               end else begin
                  f_we  = 1'b1;
                  ft_in = ptr_next(ft_ff);
               end
            end
         end
         S_RSP2: begin
            rv_in  = 1'b1;
            rsp_in = pend_ff;
            state_in = S_IDLE;
         end
         S_SFIND: begin
            // s_rdata_ff holds entry idx_ff
            s_raddr = idx_ff;
            if (idx_ff == st_ff) begin
               idx_in = fh_ff; f_raddr = fh_ff;
               state_in = S_FWAIT;
            end else if (s_rdata_ff.id == req_ff.requester_id) begin
               s_raddr = ptr_next(idx_ff);
               state_in = S_SWAIT;
            end else begin
               idx_in  = ptr_next(idx_ff);
               s_raddr = ptr_next(idx_ff);
               state_in = S_SWAIT;
               pend_in.last = 1'b0; // marks still searching
            end
            if (idx_ff != st_ff && s_rdata_ff.id == req_ff.requester_id)
               pend_in.last = 1'b1;
         end
         S_SWAIT: begin
            s_raddr = pend_ff.last ? ptr_next(idx_ff) : idx_ff;
            state_in = pend_ff.last ? S_SSHFT : S_SFIND;
         end
         S_SSHFT: begin
            // s_rdata_ff holds entry idx+1
            if (ptr_next(idx_ff) == st_ff) begin
               st_in = ptr_prev(st_ff);
               idx_in = fh_ff; f_raddr = fh_ff;
               state_in = S_FWAIT;
            end else begin
               s_we = 1'b1; s_waddr = idx_ff; s_wdata = s_rdata_ff;
               idx_in = ptr_next(idx_ff);
               s_raddr = ptr_next(ptr_next(idx_ff));
               state_in = S_SWAIT;
            end
         end
         S_FWAIT: begin
            f_raddr = pend_ff.last ? ptr_next(idx_ff) : idx_ff;
            state_in = (idx_ff == fh_ff && !pend_ff.last) ? S_FFIND :
                       (pend_ff.last ? S_FSHFT : S_FFIND);
         end
         S_FFIND: begin
            f_raddr = idx_ff;
            if (idx_ff == ft_ff) begin
               state_in = S_HOLD;
            end else if (f_rdata_ff == req_ff.requester_id) begin
               pend_in.last = 1'b1;
               state_in = S_FWAIT;
            end else begin
               pend_in.last = 1'b0;
               idx_in = ptr_next(idx_ff);
               state_in = S_FWAIT;
            end
         end
         S_FSHFT: begin
            if (ptr_next(idx_ff) == ft_ff) begin
               ft_in = ptr_prev(ft_ff);
               state_in = S_HOLD;
            end else begin
               f_we = 1'b1; f_waddr = idx_ff; f_wdata = f_rdata_ff;
               idx_in = ptr_next(idx_ff);
               state_in = S_FWAIT;
            end
         end
         S_HOLD: begin
            // read store head for possible wake
            s_raddr = sh_ff;
            state_in = S_HRD;
            if (!(holder_valid_ff && holder_id_ff == req_ff.requester_id))
               state_in = S_IDLE;
         end
         S_HRD: begin
            state_in = S_IDLE;
            holder_valid_in = 1'b0;
            if (slot_full_ff) begin
               slot_full_in = 1'b0;
               if (!s_empty) begin
                  sh_in = ptr_next(sh_ff);
                  slot_value_in = s_rdata_ff.data;
                  slot_full_in = 1'b1;
                  holder_id_in = s_rdata_ff.id;
                  holder_valid_in = 1'b1;
                  rv_in  = 1'b1;
                  rsp_in = mk(s_rdata_ff.id, ST_OK, s_rdata_ff.data, 1'b1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // search flag starts clear on each exit walk phase
      if (state_ff == S_RD || (state_ff == S_SFIND && idx_ff == st_ff) ||
          (state_ff == S_SSHFT && ptr_next(idx_ff) == st_ff))
         pend_in.last = 1'b0;
   end

endmodule

// File: rtl/core/bmbx_checker.sv
// ----------------------------------------------------------------------------
// bmbx_checker
// Port-level checks for the mailbox, bound to the top level.
// ----------------------------------------------------------------------------
module bmbx_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input bmbx_pkg::rsp_type rsp_item
);
   import bmbx_pkg::*;

   // an accepted item makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");

   // no reply once the block has settled idle (busy low now and in the $past samples)
   a_idle: assert property (@(posedge clock) disable iff (reset)
      !busy && $past(!busy) && $past(!busy, 2) |-> !rsp_valid)
      else $error("reply while idle");

   // a reply without last is followed by another reply
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |=> rsp_valid)
      else $error("first reply not followed");

   // no reply in the first cycle after acceptance
   a_lat: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid) else $error("early reply");

endmodule

bind blocking_mailbox_with_wait_queues bmbx_checker u_bmbx_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_item(rsp_item)
);
